FILE: design/skvt_pkg.sv
// shared constants, payload types and control structs for the sorted key/value table
package skvt_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_UPSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_GET    = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key;
    logic [31:0] value;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic [4:0]  entry_count;
    logic        full_res;
  } res_t;

  // read address sources of the table memories
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_POS,
    RD_IDX_P1,
    RD_CNT_M1,
    RD_IDX_M2,
    RD_P_P1,
    RD_IDX_P2
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    get_res;
    logic    set_ok;
    logic    set_full;
    logic    idx_cnt;
    logic    idx_p;
    logic    idx_inc;
    logic    idx_dec;
    logic    move;
    logic    wr_new;
    logic    wr_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       scan_stop;
    logic       hit;
    logic       full;
    logic       up_done;
    logic       dn_done;
  } stat_t;

endpackage

FILE: design/skvt_dpath.sv
// table memories, request and walk registers, result staging and output register
module skvt_dpath import skvt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  in_data_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output res_t  out_data_o
);

  logic [31:0] key_mem [ENTRIES];
  logic [31:0] val_mem [ENTRIES];

  logic [31:0] key_rd_q, val_rd_q;
  req_t        req_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] p_q, count_q;
  logic        hit_q, ok_q, full_q;
  logic [31:0] kout_q, vout_q;
  res_t        out_q;

  logic [CNT_W-1:0] rd_wide;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic        key_we, val_we;
  logic [31:0] key_wd, val_wd;
  logic        in_range, scan_stop, hit_now, pos_ok;

  assign in_range  = idx_q < count_q;
  assign hit_now   = in_range && (key_rd_q == req_q.key);
  // first entry whose key is not below the request key, or end of table
  assign scan_stop = !in_range || (key_rd_q >= req_q.key);
  assign pos_ok    = CNT_W'(req_q.position) < count_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO:   rd_wide = '0;
      RD_POS:    rd_wide = CNT_W'(in_data_i.position);
      RD_IDX_P1: rd_wide = idx_q + CNT_W'(1);
      RD_CNT_M1: rd_wide = count_q - CNT_W'(1);
      RD_IDX_M2: rd_wide = idx_q - CNT_W'(2);
      RD_P_P1:   rd_wide = p_q + CNT_W'(1);
      RD_IDX_P2: rd_wide = idx_q + CNT_W'(2);
      default:   rd_wide = '0;
    endcase
  end
  assign rd_addr = rd_wide[IDX_W-1:0];

  assign key_we  = cmd_i.move || cmd_i.wr_new;
  assign val_we  = cmd_i.move || cmd_i.wr_new || cmd_i.wr_val;
  assign wr_addr = cmd_i.move ? idx_q[IDX_W-1:0] : p_q[IDX_W-1:0];
  assign key_wd  = cmd_i.move ? key_rd_q : req_q.key;
  assign val_wd  = cmd_i.move ? val_rd_q : req_q.value;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wd;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_wd;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.scan && !scan_stop) begin
      idx_d = idx_q + CNT_W'(1);
    end else if (cmd_i.idx_cnt) begin
      idx_d = count_q;
    end else if (cmd_i.idx_p) begin
      idx_d = p_q;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CNT_W'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      req_q  <= in_data_i;
      ok_q   <= 1'b0;
      full_q <= 1'b0;
      hit_q  <= 1'b0;
      kout_q <= '0;
      vout_q <= '0;
    end else begin
      if (cmd_i.scan && scan_stop) begin
        p_q   <= idx_q;
        hit_q <= hit_now;
        if (hit_now && req_q.operation == OP_LOOKUP) begin
          vout_q <= val_rd_q;
        end
      end
      if (cmd_i.get_res && pos_ok) begin
        ok_q   <= 1'b1;
        kout_q <= key_rd_q;
        vout_q <= val_rd_q;
      end
      if (cmd_i.set_ok) begin
        ok_q <= 1'b1;
      end
      if (cmd_i.set_full) begin
        full_q <= 1'b1;
      end
    end
    if (cmd_i.res_load) begin
      out_q.ok          <= ok_q;
      out_q.key_out     <= kout_q;
      out_q.value_out   <= vout_q;
      out_q.entry_count <= 5'(count_q);
      out_q.full_res    <= full_q;
    end
  end

  assign stat_o.op        = req_q.operation;
  assign stat_o.scan_stop = scan_stop;
  assign stat_o.hit       = hit_q;
  assign stat_o.full      = count_q == CNT_W'(ENTRIES);
  assign stat_o.up_done   = idx_q == p_q;
  assign stat_o.dn_done   = (idx_q + CNT_W'(1)) >= count_q;
  assign out_data_o       = out_q;

endmodule

FILE: design/skvt_ctrl.sv
// sequencer: key scan, insert/erase shifts and result handoff
module skvt_ctrl import skvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_op_i,
  input  logic       out_ready_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       in_ready_o,
  output logic       out_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GET,
    S_EXEC,
    S_SHUP,
    S_SHDN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;

  assign in_ready_o = state_q == S_IDLE;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_ZERO;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          if (in_op_i == OP_GET) begin
            cmd_o.rd_sel = RD_POS;
            state_d      = S_GET;
          end else if (in_op_i > OP_GET) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_GET: begin
        cmd_o.get_res = 1'b1;
        state_d       = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.rd_sel = RD_IDX_P1;
        if (stat_i.scan_stop) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_INSERT, OP_UPSERT: begin
            if (stat_i.hit) begin
              if (stat_i.op == OP_UPSERT) begin
                cmd_o.wr_val = 1'b1;
                cmd_o.set_ok = 1'b1;
              end
            end else if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.rd_sel  = RD_CNT_M1;
              cmd_o.idx_cnt = 1'b1;
              state_d       = S_SHUP;
            end
          end
          OP_UPDATE: begin
            cmd_o.wr_val = stat_i.hit;
            cmd_o.set_ok = stat_i.hit;
          end
          OP_ERASE: begin
            if (stat_i.hit) begin
              cmd_o.rd_sel = RD_P_P1;
              cmd_o.idx_p  = 1'b1;
              state_d      = S_SHDN;
            end
          end
          OP_LOOKUP: begin
            cmd_o.set_ok = stat_i.hit;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SHUP: begin
        cmd_o.rd_sel = RD_IDX_M2;
        if (!stat_i.up_done) begin
          cmd_o.move    = 1'b1;
          cmd_o.idx_dec = 1'b1;
        end else begin
          // hole is open at the insert point
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.set_ok  = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_SHDN: begin
        cmd_o.rd_sel = RD_IDX_P2;
        if (!stat_i.dn_done) begin
          cmd_o.move    = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.set_ok  = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/sorted_key_value_table_core.sv
// sorted key/value table: up to 16 unique keys kept in ascending order
// sequence: get by index reads its position directly, an unused code goes straight to the result,
//   the others scan the keys from position 0 up to the point where the scan stops, and an insert
//   of a new key or an erase of a found key then shifts the entries behind that point
// throughput: one request at a time, the next is taken once its result is in the output register
// reset: entry count cleared at once, memory contents left undefined, no clearing pass
module sorted_key_value_table_core import skvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  skvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  skvt_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // one request in flight: a transfer in closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a request is in flight");

  // the table memories are only written while a request is being worked
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.move || cmd.wr_new || cmd.wr_val) |-> !in_ready_o)
    else $error("table write outside a request");

  // a refused insert never reports success
  a_full_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.full_res) |-> !out_data_o.ok)
    else $error("full refusal reported as success");

  // count stays within the table size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.entry_count <= 5'(ENTRIES)))
    else $error("entry count beyond table size");
`endif

endmodule

FILE: bench/tb.sv
// testbench for the sorted key/value table core: predicted results checked per transfer
`timescale 1ns / 1ps

module tb import skvt_pkg::*;;

  localparam int unsigned RAND_ITEMS  = 500;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 60;
  // operation codes the block does not define
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  res_t out_data_o;

  sorted_key_value_table_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the table
  logic [31:0] tbl_key [ENTRIES];
  logic [31:0] tbl_val [ENTRIES];
  int unsigned tbl_cnt = 0;

  res_t        expected_q[$];
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned spare_sent = 0;
  int unsigned full_refusals = 0;
  int unsigned fills = 0;
  int unsigned cycles = 0;
  bit          burst_mode = 1'b0;

  function automatic res_t table_apply(req_t r);
    int unsigned p;
    int unsigned i;
    logic        hit;
    res_t        res;
    res = '0;
    p = 0;
    while (p < tbl_cnt && tbl_key[p] < r.key) p++;
    hit = (p < tbl_cnt) && (tbl_key[p] == r.key);
    case (r.operation)
      OP_INSERT, OP_UPSERT: begin
        if (hit) begin
          if (r.operation == OP_UPSERT) begin
            tbl_val[p] = r.value;
            res.ok = 1'b1;
          end
        end else if (tbl_cnt >= ENTRIES) begin
          res.full_res = 1'b1;
          full_refusals++;
        end else begin
          for (i = tbl_cnt; i > p; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[p] = r.key;
          tbl_val[p] = r.value;
          tbl_cnt++;
          res.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (hit) begin
          tbl_val[p] = r.value;
          res.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          for (i = p; i + 1 < tbl_cnt; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_val[i] = tbl_val[i+1];
          end
          tbl_cnt--;
          res.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res.value_out = tbl_val[p];
          res.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (r.position < tbl_cnt) begin
          res.key_out   = tbl_key[r.position];
          res.value_out = tbl_val[r.position];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(tbl_cnt);
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    if (burst_mode || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic req_t mk_req(logic [2:0] op, logic [31:0] key, logic [31:0] value,
                                  logic [3:0] position);
    req_t r;
    r.operation = op;
    r.key       = key;
    r.value     = value;
    r.position  = position;
    return r;
  endfunction

  // keys biased toward hits, near misses and the extremes
  function automatic logic [31:0] pick_key();
    int unsigned w;
    logic [31:0] k;
    w = $urandom_range(0, 99);
    if (tbl_cnt > 0 && w < 50) begin
      k = tbl_key[$urandom_range(0, tbl_cnt - 1)];
    end else if (tbl_cnt > 0 && w < 65) begin
      k = tbl_key[$urandom_range(0, tbl_cnt - 1)];
      k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
    end else if (w < 75) begin
      case ($urandom_range(0, 3))
        0: k = 32'h0000_0000;
        1: k = 32'hFFFF_FFFF;
        2: k = 32'h7FFF_FFFF;
        default: k = 32'h8000_0000;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 20) return OP_INSERT;
    if (w < 35) return OP_UPDATE;
    if (w < 50) return OP_UPSERT;
    if (w < 65) return OP_ERASE;
    if (w < 85) return OP_LOOKUP;
    return OP_GET;
  endfunction

  task automatic send_req(req_t r);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(table_apply(r));
    if (r.operation > OP_GET) spare_sent++;
    else requests_sent++;
  endtask

  // output side: a freshly drawn stall, possibly none, before every result
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $realtime, out_data_o);
      end else begin
        exp_r = expected_q.pop_front();
        results_checked++;
        compare_field("ok", 32'(exp_r.ok), 32'(out_data_o.ok));
        compare_field("key_out", exp_r.key_out, out_data_o.key_out);
        compare_field("value_out", exp_r.value_out, out_data_o.value_out);
        compare_field("entry_count", 32'(exp_r.entry_count), 32'(out_data_o.entry_count));
        compare_field("full_res", 32'(exp_r.full_res), 32'(out_data_o.full_res));
      end
    end
  end

  // every operation on a small table, extremes of the key and value range
  task automatic test_directed();
    burst_mode = 1'b0;
    send_req(mk_req(OP_GET,    32'h0000_0000, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15));
    send_req(mk_req(OP_ERASE,  32'h0000_0005, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0));
    send_req(mk_req(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 4'd0));
    send_req(mk_req(OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 4'd0));
    // duplicate insert leaves the stored value alone
    send_req(mk_req(OP_INSERT, 32'h0000_0000, 32'h1111_1111, 4'd0));
    send_req(mk_req(OP_UPDATE, 32'h1234_5678, 32'h2222_2222, 4'd0));
    send_req(mk_req(OP_UPDATE, 32'h8000_0000, 32'h0123_4567, 4'd0));
    send_req(mk_req(OP_UPSERT, 32'h0000_0000, 32'h89AB_CDEF, 4'd0));
    send_req(mk_req(OP_UPSERT, 32'h0000_0001, 32'h3333_3333, 4'd0));
    send_req(mk_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_LOOKUP, 32'h8000_0001, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0));
    send_req(mk_req(OP_GET,    32'h0000_0000, 32'h0000_0000, 4'd4));
    send_req(mk_req(OP_GET,    32'h0000_0000, 32'h0000_0000, 4'd5));
    send_req(mk_req(OP_GET,    32'h0000_0000, 32'h0000_0000, 4'd15));
    send_req(mk_req(OP_SPARE_LO, 32'h0000_0001, 32'hFFFF_FFFF, 4'd0));
    send_req(mk_req(OP_SPARE_HI, 32'hFFFF_FFFF, 32'h0000_0000, 4'd15));
    send_req(mk_req(OP_ERASE,  32'h7FFF_FFFF, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_ERASE,  32'h7FFF_FFFF, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 4'd0));
    send_req(mk_req(OP_ERASE,  32'h0000_0000, 32'h0000_0000, 4'd0));
  endtask

  // fill to capacity, push against the limit, then read every position
  task automatic test_fill_and_overflow();
    req_t r;
    int unsigned i;
    burst_mode = ($urandom_range(0, 3) == 0);
    while (tbl_cnt < ENTRIES) begin
      r = mk_req($urandom_range(0, 4) == 0 ? OP_UPSERT : OP_INSERT,
                 $urandom_range(0, 6) == 0 ? pick_key() : $urandom,
                 $urandom, 4'($urandom));
      send_req(r);
    end
    fills++;
    for (i = 0; i < 8; i++) begin
      r = mk_req($urandom_range(0, 1) ? OP_UPSERT : OP_INSERT, pick_key(), $urandom,
                 4'($urandom));
      send_req(r);
    end
    for (i = 0; i < ENTRIES; i++) begin
      send_req(mk_req(OP_GET, $urandom, $urandom, 4'(i)));
    end
  endtask

  task automatic test_mixed_traffic(int unsigned n);
    int unsigned i;
    burst_mode = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n; i++) begin
      send_req(mk_req(pick_op(), pick_key(), $urandom, 4'($urandom)));
    end
  endtask

  task automatic test_drain();
    logic [31:0] k;
    burst_mode = ($urandom_range(0, 3) == 0);
    while (tbl_cnt > 0) begin
      if ($urandom_range(0, 6) == 0) k = $urandom;
      else k = tbl_key[$urandom_range(0, tbl_cnt - 1)];
      send_req(mk_req(OP_ERASE, k, $urandom, 4'($urandom)));
    end
  endtask

  // every field fully random, unused codes included
  task automatic test_noise(int unsigned n);
    int unsigned i;
    burst_mode = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n; i++) begin
      send_req(mk_req(3'($urandom), $urandom, $urandom, 4'($urandom)));
    end
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned rand_target;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    rand_target = requests_sent + RAND_ITEMS;
    while (requests_sent < rand_target) begin
      test_fill_and_overflow();
      test_mixed_traffic(80);
      test_drain();
      test_noise(15);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("checked %0d results from %0d table requests and %0d unused codes",
             results_checked, requests_sent, spare_sent);
    $display("table filled to capacity %0d times, %0d inserts refused as full",
             fills, full_refusals);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
